// File: hdl/wav_data_chunk_locator_defines.svh
// assertion macros for the wav data chunk locator
`ifndef WAV_DATA_CHUNK_LOCATOR_DEFINES_SVH
`define WAV_DATA_CHUNK_LOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define WDCL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WDCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WDCL_ASSERT_SAME(lbl, ante, cons, msg)
`define WDCL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hdl/wdcl_pkg.sv
// constants and field widths shared by the wav data chunk locator
`default_nettype none
package wdcl_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TDATA_W = 3 * WORD_W;

  localparam logic [WORD_W-1:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6461_7461;

  localparam logic [WORD_W-1:0] RIFF_HDR_LEN  = 32'd12;
  localparam logic [WORD_W-1:0] CHUNK_HDR_LEN = 32'd8;
  localparam logic [WORD_W-1:0] POS_RIFF_END  = 32'd3;
  localparam logic [WORD_W-1:0] POS_WAVE_END  = 32'd11;
  localparam logic [WORD_W-1:0] POS_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_BAD_HDR = 2'd1,
    ST_NO_DATA = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

endpackage
`default_nettype wire

// File: hdl/wav_data_chunk_locator.sv
// top level: streaming riff/wave parser that locates the pcm data chunk
//
// Takes a wav file one byte per request on in_*, offset 0 marked by in_tuser.
// The user must write the file length on the cfg_* channel only while no byte
// or result is in flight; the block itself does not enforce this. The block
// checks the riff/wave header, skips non-data chunks (with their pad byte) and
// emits one result per file on out_*: status in out_tuser and data start,
// clamped data length and pcm length in out_tdata. A byte is taken every cycle
// unless a stalled result and a full input register hold it off; each byte
// passes an input register and then compare/add logic that updates the parse
// state and the registered result on out_*. A stalled result holds off new
// bytes only once the input register is full. After a result, bytes are
// dropped until the next start-of-file byte.
`default_nettype none
`include "wav_data_chunk_locator_defines.svh"
module wav_data_chunk_locator
  import wdcl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [WORD_W-1:0]   cfg_data,   // file length
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [BYTE_W-1:0]   in_tdata,   // data_byte
  input  wire logic                in_tuser,   // start_of_file
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [TDATA_W-1:0]       out_tdata,  // data_start, data_bytes, pcm_len
  output logic [STAT_W-1:0]        out_tuser   // status
);

  typedef enum logic [1:0] {PH_HEADER, PH_CHUNK, PH_DONE} phase_t;

  logic [WORD_W-1:0]  fsz_r;
  logic               s1_valid_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_sof_r;
  logic               out_free;
  logic               s1_adv;

  phase_t             phase_r, phase_e, phase_nxt;
  logic [WORD_W-1:0]  pos_r, pos_e, pos_nxt;
  logic [WORD_W-1:0]  cs_r, cs_e, cs_nxt;
  logic [WORD_W-1:0]  id_r, id_e, id_nxt, id_shift;
  logic [WORD_W-1:0]  sz_r, sz_e, sz_nxt, sz_or;
  logic               hok_r, hok_e, hok_nxt;

  logic [WORD_W:0]    diff;
  logic               in_hdr;
  logic [2:0]         k;
  logic [WORD_W:0]    dstart;
  logic [WORD_W:0]    rem;
  logic [WORD_W-1:0]  len;
  logic [WORD_W+1:0]  next_cs;
  logic [WORD_W:0]    fsz_m8;
  logic               no_room;

  logic               emit;
  status_t            st;
  logic [WORD_W-1:0]  off_v, dlen_v, plen_v;

  logic               out_tvalid_r;
  logic [TDATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0]  out_tuser_r;

  logic               res_fail;
  logic               res_data;
  logic               res_off_ok;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_tvalid_r || out_tready;
  assign s1_adv     = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // restart applies before the byte is processed
  always_comb begin
    phase_e = s1_sof_r ? PH_HEADER : phase_r;
    pos_e   = s1_sof_r ? '0 : pos_r;
    cs_e    = s1_sof_r ? RIFF_HDR_LEN : cs_r;
    id_e    = s1_sof_r ? '0 : id_r;
    sz_e    = s1_sof_r ? '0 : sz_r;
    hok_e   = s1_sof_r ? 1'b1 : hok_r;
  end

  assign id_shift = {id_e[WORD_W-BYTE_W-1:0], s1_byte_r};

  // position within the current chunk header
  assign diff   = {1'b0, pos_e} - {1'b0, cs_e};
  assign in_hdr = !diff[WORD_W] && (diff[WORD_W-1:3] == '0);
  assign k      = diff[2:0];

  always_comb begin
    unique case (k[1:0])
      2'd0:    sz_or = sz_e | {24'd0, s1_byte_r};
      2'd1:    sz_or = sz_e | {16'd0, s1_byte_r, 8'd0};
      2'd2:    sz_or = sz_e | {8'd0, s1_byte_r, 16'd0};
      default: sz_or = sz_e | {s1_byte_r, 24'd0};
    endcase
  end

  assign dstart  = {1'b0, cs_e} + {1'b0, CHUNK_HDR_LEN};
  assign rem     = {1'b0, fsz_r} - dstart;
  assign len     = ({1'b0, sz_or} > rem) ? rem[WORD_W-1:0] : sz_or;
  assign next_cs = {1'b0, dstart} + {2'b00, sz_or} + {{(WORD_W+1){1'b0}}, sz_or[0]};
  assign fsz_m8  = {1'b0, fsz_r} - {1'b0, CHUNK_HDR_LEN};
  assign no_room = fsz_m8[WORD_W] || (next_cs > {1'b0, fsz_m8});

  always_comb begin
    phase_nxt = phase_e;
    cs_nxt    = cs_e;
    id_nxt    = id_e;
    sz_nxt    = sz_e;
    hok_nxt   = hok_e;
    emit      = 1'b0;
    st        = ST_FOUND;
    off_v     = '0;
    dlen_v    = '0;
    plen_v    = '0;
    pos_nxt   = (pos_e == POS_MAX) ? pos_e : pos_e + 32'd1;
    unique case (phase_e)
      PH_HEADER: begin
        if (pos_e == '0 && fsz_r < RIFF_HDR_LEN) begin
          emit = 1'b1;
          st   = ST_BAD_HDR;
        end else begin
          id_nxt = id_shift;
          if (pos_e == POS_RIFF_END && id_shift != TAG_RIFF) begin
            hok_nxt = 1'b0;
          end
          if (pos_e == POS_WAVE_END) begin
            if (!hok_e || id_shift != TAG_WAVE) begin
              emit = 1'b1;
              st   = ST_BAD_HDR;
            end else begin
              phase_nxt = PH_CHUNK;
              cs_nxt    = RIFF_HDR_LEN;
              id_nxt    = '0;
              sz_nxt    = '0;
              if (fsz_r < RIFF_HDR_LEN + CHUNK_HDR_LEN) begin
                emit = 1'b1;
                st   = ST_NO_DATA;
              end
            end
          end
        end
      end
      PH_CHUNK: begin
        if (in_hdr) begin
          if (!k[2]) begin
            id_nxt = id_shift;
          end else begin
            sz_nxt = sz_or;
            if (k == 3'd7) begin
              if (id_e == TAG_DATA) begin
                emit = 1'b1;
                if (dstart >= {1'b0, fsz_r}) begin
                  st = ST_NO_DATA;
                end else begin
                  off_v  = dstart[WORD_W-1:0];
                  dlen_v = len;
                  plen_v = {len[WORD_W-1:2], 2'b00};
                  st     = (len[WORD_W-1:2] == '0) ? ST_SHORT : ST_FOUND;
                end
              end else begin
                cs_nxt = next_cs[WORD_W-1:0];
                id_nxt = '0;
                sz_nxt = '0;
                if (no_room) begin
                  emit = 1'b1;
                  st   = ST_NO_DATA;
                end
              end
            end
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsz_r        <= '0;
      s1_valid_r   <= 1'b0;
      phase_r      <= PH_HEADER;
      pos_r        <= '0;
      cs_r         <= RIFF_HDR_LEN;
      id_r         <= '0;
      sz_r         <= '0;
      hok_r        <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        fsz_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        cs_r    <= cs_nxt;
        id_r    <= id_nxt;
        sz_r    <= sz_nxt;
        hok_r   <= hok_nxt;
      end
      if (s1_adv && emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_sof_r  <= in_tuser;
    end
    if (s1_adv && emit) begin
      out_tdata_r <= {plen_v, dlen_v, off_v};
      out_tuser_r <= st;
    end
  end

  assign res_fail   = out_tvalid_r && (out_tuser_r == ST_BAD_HDR || out_tuser_r == ST_NO_DATA);
  assign res_data   = out_tvalid_r && !res_fail;
  assign res_off_ok = out_tdata_r[WORD_W-1:0] >= RIFF_HDR_LEN + CHUNK_HDR_LEN;

  `WDCL_ASSERT_NEXT(a_done_phase, s1_adv && emit, phase_r == PH_DONE, "no done phase")
  `WDCL_ASSERT_SAME(a_stall_means_full, !in_tready, s1_valid_r, "stall with empty stage")
  `WDCL_ASSERT_SAME(a_pcm_aligned, out_tvalid_r, out_tdata_r[2*WORD_W +: 2] == '0, "pcm unaligned")
  `WDCL_ASSERT_SAME(a_fail_zero, res_fail, out_tdata_r == '0, "failure result carries data")
  `WDCL_ASSERT_SAME(a_found_offset, res_data, res_off_ok, "data start inside riff header")

endmodule
`default_nettype wire
